@@ hw/rtl/ardc_pkg.sv @@
// Package for the AND-rotate differential counter.
// Holds the trellis types, pipeline constants and rotate helpers.
// No dependencies.
package ardc_pkg;

  localparam int WORD_W          = 16;
  localparam int CNT_W           = 16;
  localparam int TOTAL_W         = 18;
  localparam int PATH_W          = 17;
  localparam int EXPO_W          = 7;
  localparam int NUM_NODES       = 4;
  localparam int ROT_STEP        = 7;
  localparam int NUM_STEPS       = 15;
  localparam int STEPS_PER_STAGE = 3;
  localparam int NUM_TSTAGES     = NUM_STEPS / STEPS_PER_STAGE;
  localparam int PIPE_DEPTH      = NUM_TSTAGES + 3;
  localparam int IN_DATA_W       = 32;
  localparam int OUT_DATA_W      = 24;

  localparam logic [PATH_W-1:0] COUNT_CAP     = 17'h10000;
  localparam logic [EXPO_W-1:0] ZERO_EXPONENT = 7'd100;

  typedef logic [CNT_W-1:0] count_t;
  typedef count_t [NUM_NODES-1:0] lane_t;
  typedef lane_t [NUM_NODES-1:0] trel_t;
  typedef logic [NUM_NODES-1:0][WORD_W-1:0] hit_t;
  typedef logic [STEPS_PER_STAGE-1:0][NUM_NODES-1:0] step_hits_t;

  function automatic logic [WORD_W-1:0] rol16(input logic [WORD_W-1:0] x, input int s);
    return (x << s) | (x >> (WORD_W - s));
  endfunction

  function automatic logic [3:0] step_pos(input int k);
    return 4'((k * ROT_STEP) % WORD_W);
  endfunction

endpackage

@@ hw/rtl/ardc_trel_stage.sv @@
// Three consecutive trellis steps for all four start lanes.
// Purely combinational; the top level registers the counts between stages.
// Depends on ardc_pkg.
module ardc_trel_stage (
  input  ardc_pkg::trel_t      cnt_in,
  input  ardc_pkg::step_hits_t hits,
  output ardc_pkg::trel_t      cnt_out
);

  always_comb begin
    ardc_pkg::trel_t cur;
    ardc_pkg::count_t s01;
    ardc_pkg::count_t s23;
    cur = cnt_in;
    for (int j = 0; j < ardc_pkg::STEPS_PER_STAGE; j++) begin
      for (int t = 0; t < ardc_pkg::NUM_NODES; t++) begin
        s01 = ardc_pkg::CNT_W'(cur[t][0] + cur[t][1]);
        s23 = ardc_pkg::CNT_W'(cur[t][2] + cur[t][3]);
        cur[t][0] = hits[j][0] ? s01 : '0;
        cur[t][2] = hits[j][2] ? s01 : '0;
        cur[t][1] = hits[j][1] ? s23 : '0;
        cur[t][3] = hits[j][3] ? s23 : '0;
      end
    end
    cnt_out = cur;
  end

endmodule

@@ hw/rtl/and_rotate_differential_count.sv @@
// Top level of the AND-rotate differential counter: eight register stages.
// One transaction is accepted per cycle unless the pipeline stalls; each stage stalls only
// when it and all stages after it are full, so bubbles are squeezed out under back-pressure.
// A synchronous active-low reset clears every valid bit. Depends on ardc_pkg
// and ardc_trel_stage.
module and_rotate_differential_count (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // input_diff [15:0], output_diff [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // path_count [16:0], weight_exponent [23:17]
);

  localparam int LAST = ardc_pkg::PIPE_DEPTH - 1;

  logic [ardc_pkg::PIPE_DEPTH-1:0] vld_r;
  logic [ardc_pkg::PIPE_DEPTH-1:0] en;

  ardc_pkg::hit_t  hit_r [ardc_pkg::NUM_TSTAGES];
  ardc_pkg::trel_t cnt_r [ardc_pkg::NUM_TSTAGES+1];
  ardc_pkg::trel_t cnt_nxt [ardc_pkg::NUM_TSTAGES];

  logic [ardc_pkg::WORD_W-1:0]  in_a;
  logic [ardc_pkg::WORD_W-1:0]  in_b;
  logic [ardc_pkg::WORD_W-1:0]  p, q, d;
  ardc_pkg::hit_t               hit_nxt;
  ardc_pkg::trel_t              init_nxt;
  logic [ardc_pkg::TOTAL_W-1:0] total_nxt;
  logic [ardc_pkg::TOTAL_W-1:0] total_r;
  logic [ardc_pkg::PATH_W-1:0]  sat;
  logic [ardc_pkg::EXPO_W-1:0]  expo_nxt;
  logic [ardc_pkg::PATH_W-1:0]  path_count_r;
  logic [ardc_pkg::EXPO_W-1:0]  weight_exponent_r;

  // Stall chain: a stage may load when empty or when its successor loads.
  always_comb begin
    en[LAST] = !vld_r[LAST] || out_tready;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i <= LAST; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Node masks, match bits and start counts.
  assign in_a = in_tdata[15:0];
  assign in_b = in_tdata[31:16];

  always_comb begin
    logic [ardc_pkg::WORD_W-1:0] mask [ardc_pkg::NUM_NODES];
    p = ardc_pkg::rol16(in_a, 1);
    q = ardc_pkg::rol16(p, ardc_pkg::ROT_STEP);
    d = in_b ^ ardc_pkg::rol16(in_a, 2);
    mask[0] = p & q;
    mask[1] = p & ~q;
    mask[2] = ~p & q;
    mask[3] = p | q;
    init_nxt = '0;
    for (int n = 0; n < ardc_pkg::NUM_NODES; n++) begin
      hit_nxt[n] = ~(d ^ mask[n]);
      init_nxt[n][n] = ardc_pkg::CNT_W'(hit_nxt[n][0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hit_r[0] <= hit_nxt;
      cnt_r[0] <= init_nxt;
    end
  end

  for (genvar g = 0; g < ardc_pkg::NUM_TSTAGES; g++) begin : g_trel
    ardc_pkg::step_hits_t stage_hits;

    for (genvar j = 0; j < ardc_pkg::STEPS_PER_STAGE; j++) begin : g_step
      for (genvar n = 0; n < ardc_pkg::NUM_NODES; n++) begin : g_node
        assign stage_hits[j][n] =
          hit_r[g][n][ardc_pkg::step_pos(g * ardc_pkg::STEPS_PER_STAGE + j + 1)];
      end
    end

    ardc_trel_stage u_stage (
      .cnt_in  (cnt_r[g]),
      .hits    (stage_hits),
      .cnt_out (cnt_nxt[g])
    );

    always_ff @(posedge clk) begin
      if (en[g+1]) begin
        cnt_r[g+1] <= cnt_nxt[g];
      end
    end

    if (g + 1 < ardc_pkg::NUM_TSTAGES) begin : g_hit
      always_ff @(posedge clk) begin
        if (en[g+1]) begin
          hit_r[g+1] <= hit_r[g];
        end
      end
    end
  end

  // Closed paths end on nodes 0/1 for starts 0 and 2, and on nodes 2/3 otherwise.
  always_comb begin
    ardc_pkg::trel_t c;
    c = cnt_r[ardc_pkg::NUM_TSTAGES];
    total_nxt = ardc_pkg::TOTAL_W'(c[0][0]) + ardc_pkg::TOTAL_W'(c[0][1])
              + ardc_pkg::TOTAL_W'(c[1][2]) + ardc_pkg::TOTAL_W'(c[1][3])
              + ardc_pkg::TOTAL_W'(c[2][0]) + ardc_pkg::TOTAL_W'(c[2][1])
              + ardc_pkg::TOTAL_W'(c[3][2]) + ardc_pkg::TOTAL_W'(c[3][3]);
  end

  always_ff @(posedge clk) begin
    if (en[LAST-1]) begin
      total_r <= total_nxt;
    end
  end

  always_comb begin
    logic [ardc_pkg::EXPO_W-1:0] lg;
    if (total_r > ardc_pkg::TOTAL_W'(ardc_pkg::COUNT_CAP)) begin
      sat = ardc_pkg::COUNT_CAP;
    end else begin
      sat = total_r[ardc_pkg::PATH_W-1:0];
    end
    lg = '0;
    for (int i = 0; i < ardc_pkg::PATH_W; i++) begin
      if (sat[i]) begin
        lg = ardc_pkg::EXPO_W'(i);
      end
    end
    if (sat == '0) begin
      expo_nxt = ardc_pkg::ZERO_EXPONENT;
    end else if ((sat & (sat - 1'b1)) == '0) begin
      expo_nxt = ardc_pkg::EXPO_W'(16) - lg;
    end else begin
      expo_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      path_count_r      <= sat;
      weight_exponent_r <= expo_nxt;
    end
  end

  assign out_tvalid = vld_r[LAST];
  assign out_tdata  = {weight_exponent_r, path_count_r};

  a_ready_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&vld_r))
    else $error("Input stalled while the pipeline still has an empty stage.");

  a_count_saturated : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[16:0] <= ardc_pkg::COUNT_CAP))
    else $error("Path count exceeds the saturation limit.");

  a_zero_exponent : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[16:0] == '0)) |-> (out_tdata[23:17] == ardc_pkg::ZERO_EXPONENT))
    else $error("A zero path count carries the wrong exponent.");

endmodule

@@ tb/path_count_checker.sv @@
// Checker for the AND-rotate differential counter: watches both stream channels,
// predicts the path count and exponent of every input transaction and compares.
// Depends on ardc_pkg for widths and constants.
module path_count_checker
  import ardc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [EXPO_W-1:0] expo;
    logic [PATH_W-1:0] count;
  } path_result_t;

  path_result_t expected_results[$];

  function automatic path_result_t predict_paths(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] p, q, d;
    logic [WORD_W-1:0] node_mask [NUM_NODES];
    int unsigned c [NUM_NODES];
    int unsigned s01, s23, total;
    int pos;
    path_result_t r;
    p = {a[14:0], a[15]};
    q = {p[8:0], p[15:9]};
    d = b ^ {a[13:0], a[15:14]};
    node_mask[0] = p & q;
    node_mask[1] = p & ~q;
    node_mask[2] = ~p & q;
    node_mask[3] = p | q;
    total = 0;
    for (int t = 0; t < NUM_NODES; t++) begin
      if (d[0] == node_mask[t][0]) begin
        for (int n = 0; n < NUM_NODES; n++) c[n] = 0;
        c[t] = 1;
        // Rotating right by seven k times brings bit 7k mod 16 down to bit 0.
        for (int k = 1; k <= NUM_STEPS; k++) begin
          pos = (k * ROT_STEP) % WORD_W;
          s01 = c[0] + c[1];
          s23 = c[2] + c[3];
          c[0] = (d[pos] == node_mask[0][pos]) ? s01 : 0;
          c[2] = (d[pos] == node_mask[2][pos]) ? s01 : 0;
          c[1] = (d[pos] == node_mask[1][pos]) ? s23 : 0;
          c[3] = (d[pos] == node_mask[3][pos]) ? s23 : 0;
        end
        total += (t == 0 || t == 2) ? c[0] + c[1] : c[2] + c[3];
      end
    end
    if (total > COUNT_CAP) total = COUNT_CAP;
    r.count = total[PATH_W-1:0];
    if (total == 0) begin
      r.expo = ZERO_EXPONENT;
    end else if ((total & (total - 1)) == 0) begin
      r.expo = EXPO_W'(WORD_W - $clog2(total));
    end else begin
      r.expo = '0;
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Inputs change only at rising edges, so the values seen at the falling edge
  // are the ones that decide each handshake at the following rising edge.
  always @(negedge clk) begin
    path_result_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_paths(in_tdata[15:0], in_tdata[31:16]));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result transaction with nothing expected: count %0d exponent %0d",
                     $realtime, got.count, got.expo);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.count !== want.count || got.expo !== want.expo) begin
            if (fail_count < 10)
              $display("%0t: mismatch: count exp %0d got %0d, exponent exp %0d got %0d",
                       $realtime, want.count, got.count, want.expo, got.expo);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ tb/tb.sv @@
// Top of the testbench for and_rotate_differential_count: clock, reset, stimulus
// with bursty input and a stalling receiver, and the final verdict.
// Depends on ardc_pkg, the block under test and path_count_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ardc_pkg::*;

  localparam int RANDOM_ITEMS = 1280;
  localparam int CYCLE_LIMIT  = 300000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int stall_left  = 0;
  int burst_left  = 0;

  always #5 clk = ~clk;

  and_rotate_differential_count u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  path_count_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** and_rotate_differential_count: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cycle_count[10:9] == 2'b11) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 4) == 0)
        stall_left <= $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6);
    end
  end

  task automatic send_pair(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
    logic rdy;
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [WORD_W-1:0] a, b, p, q, r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair(16'h0000, 16'h0000);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'h0001, 16'h0000);
    send_pair(16'h8000, 16'h0000);
    send_pair(16'h0000, 16'h0001);
    send_pair(16'h0000, 16'h8000);
    send_pair(16'hAAAA, 16'h5555);
    send_pair(16'h5555, 16'hAAAA);
    send_pair(16'h0001, 16'h0004);
    send_pair(16'h8000, 16'h0002);
    send_pair(16'h1234, 16'h48D0);
    send_pair(16'h0101, 16'h0404);
    send_pair(16'h00FF, 16'h03FC);
    send_pair(16'hFFFF, 16'hFFFE);
    send_pair(16'h7FFF, 16'hFFFD);
    send_pair(16'h0003, 16'h0000);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain();
      if (i < 300 || i > 450) pace_sender();
      a = WORD_W'($urandom);
      b = WORD_W'($urandom);
      r = WORD_W'($urandom);
      p = {a[14:0], a[15]};
      q = {p[8:0], p[15:9]};
      case ($urandom_range(0, 9))
        4, 5: begin
          a = (16'h1 << $urandom_range(0, 15)) | (16'h1 << $urandom_range(0, 15));
          b = {a[13:0], a[15:14]} ^ (16'h1 << $urandom_range(0, 15)) ^ (r & (r >> 3) & 16'h0F0F);
        end
        6: b = {a[13:0], a[15:14]};
        7: b = {a[13:0], a[15:14]} ^ ((p & q & r) | ((p | q) & ~r));
        8: a = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
        9: b = {a[13:0], a[15:14]} ^ (($urandom_range(0, 1) == 0) ? (p & q) : (p | q));
        default: ;
      endcase
      send_pair(a, b);
    end

    drain();
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** and_rotate_differential_count: PASSED **");
    end else begin
      $display("** and_rotate_differential_count: FAILED **");
    end
    $finish;
  end

endmodule
